### hw/rtl/lrm_pkg.sv
// Shared types and constants for the line resampler MAC block.
// Used by lrm_ctrl, lrm_datapath and line_resample_mac_top. No dependencies.
`timescale 1ns / 1ps

package lrm_pkg;

	// Sizes of the stores and the arithmetic
	localparam int LINE_MAX  = 1024;
	localparam int OUT_MAX   = 1024;
	localparam int TAPS_MAX  = 32;
	localparam int FRAC_BITS = 22;
	localparam int LANES     = 4;

	// Field widths
	localparam int POS_W = 10;
	localparam int TAP_W = 5;
	localparam int WGT_W = 24;
	localparam int LEN_W = 6;
	localparam int PIX_W = 8;

	// Derived widths
	localparam int LINE_AW  = $clog2(LINE_MAX);
	localparam int SRC_W    = LINE_AW + 1;
	localparam int LANE_W   = $clog2(LANES);
	localparam int GRP_W    = $clog2(TAPS_MAX / LANES);
	localparam int GCNT_W   = GRP_W + 1;
	localparam int SBANK_D  = LINE_MAX / LANES;
	localparam int WBANK_D  = OUT_MAX * TAPS_MAX / LANES;
	localparam int WBANK_AW = $clog2(WBANK_D);
	localparam int PROD_W   = PIX_W + 1 + WGT_W;
	localparam int ACC_W    = 40;

	localparam logic [LEN_W-1:0] TAPS_RESET = LEN_W'(TAPS_MAX);
	localparam logic [PIX_W-1:0] PIX_MAX    = PIX_W'(255);
	localparam logic signed [ACC_W-1:0] ACC_BIAS = ACC_W'(64'd1 << (FRAC_BITS - 1));

	// Command codes
	typedef enum logic [1:0] {
		CMD_WR_WEIGHT = 2'd0,
		CMD_WR_WINDOW = 2'd1,
		CMD_WR_PIXEL  = 2'd2,
		CMD_READ      = 2'd3
	} cmd_code_t;

	// One input item, unpacked
	typedef struct packed {
		cmd_code_t                command;
		logic [POS_W-1:0]         position;
		logic [TAP_W-1:0]         tap;
		logic signed [WGT_W-1:0]  weight;
		logic [POS_W-1:0]         window_start;
		logic [LEN_W-1:0]         window_length;
		logic [PIX_W-1:0]         pixel;
	} in_item_t;

	// Controller to datapath
	typedef struct packed {
		logic             accept;
		logic             rd_start;
		logic             win_latch;
		logic             issue;
		logic [GRP_W-1:0] grp;
		logic             mul;
		logic             acc;
		logic             out_load;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [LEN_W-1:0] len;
	} dp_stat_t;

endpackage

### hw/rtl/lrm_datapath.sv
// Datapath of the line resampler: banked pixel and weight memories, window table,
// four multiply lanes and the accumulator with rounding and clipping. Uses lrm_pkg.
`timescale 1ns / 1ps

module lrm_datapath import lrm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [LEN_W-1:0] cfg_taps,
	input  in_item_t         item,
	input  dp_cmd_t          cmd,
	output dp_stat_t         stat,
	output logic [PIX_W-1:0] out_pixel,
	output logic             out_sat
);

	logic [LEN_W-1:0]        taps_q;
	logic [POS_W-1:0]        pos_q;
	logic [POS_W+LEN_W-1:0]  win_rd_q;
	logic [POS_W-1:0]        start_q;
	logic [LEN_W-1:0]        len_q;
	logic [LEN_W-1:0]        len_clip;
	logic [POS_W+LEN_W-1:0]  win_mem [OUT_MAX];
	logic                    wgt_we, win_we, pix_we;

	logic [SRC_W-1:0]        base;
	logic [SRC_W-1:0]        src_addr [LANES];
	logic [LANES-1:0]        src_ok;
	logic [LANES-1:0]        lane_on;
	logic [WBANK_AW-1:0]     wgt_raddr;

	logic [PIX_W-1:0]        src_rd_s1 [LANES];
	logic signed [WGT_W-1:0] wgt_rd_s1 [LANES];
	logic [LANE_W-1:0]       rot_s1;
	logic [LANES-1:0]        src_ok_s1;
	logic [LANES-1:0]        lane_on_s1;

	logic [PIX_W-1:0]        px_l  [LANES];
	logic signed [WGT_W-1:0] wgt_l [LANES];
	logic signed [PROD_W-1:0] prod_s2 [LANES];
	logic signed [ACC_W-1:0] lane_sum;
	logic signed [ACC_W-1:0] acc_q;

	logic [PIX_W-1:0]        out_pixel_q;
	logic                    out_sat_q;

	assign wgt_we = cmd.accept && (item.command == CMD_WR_WEIGHT);
	assign win_we = cmd.accept && (item.command == CMD_WR_WINDOW);
	assign pix_we = cmd.accept && (item.command == CMD_WR_PIXEL);

	// Tap count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q <= TAPS_RESET;
		end else if (cfg_we) begin
			taps_q <= cfg_taps;
		end
	end

	// Window table: {length, start} per output position
	always_ff @(posedge clk) begin
		if (win_we) begin
			win_mem[item.position] <= {item.window_length, item.window_start};
		end
		if (cmd.rd_start) begin
			win_rd_q <= win_mem[item.position];
			pos_q    <= item.position;
		end
	end

	// Effective window length: smallest of stored length, tap count and slot count
	always_comb begin
		len_clip = (win_rd_q[POS_W+LEN_W-1:POS_W] < taps_q) ?
			win_rd_q[POS_W+LEN_W-1:POS_W] : taps_q;
		if (len_clip > LEN_W'(TAPS_MAX)) begin
			len_clip = LEN_W'(TAPS_MAX);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.win_latch) begin
			start_q <= win_rd_q[POS_W-1:0];
			len_q   <= len_clip;
		end
	end

	assign stat.len = len_q;

	// Group addressing: bank b serves the one source index of the group equal to b mod 4
	always_comb begin
		logic [LANE_W-1:0]        off;
		logic [GRP_W+LANE_W-1:0]  idx;
		base = {1'b0, start_q} + SRC_W'({cmd.grp, LANE_W'(0)});
		for (int b = 0; b < LANES; b++) begin
			off         = LANE_W'(b) - base[LANE_W-1:0];
			src_addr[b] = base + SRC_W'(off);
			src_ok[b]   = src_addr[b] < SRC_W'(LINE_MAX);
			idx         = {cmd.grp, LANE_W'(0)} + (GRP_W+LANE_W)'(b);
			lane_on[b]  = LEN_W'(idx) < len_q;
		end
	end

	assign wgt_raddr = {pos_q, cmd.grp};

	// Banked memories, one pixel bank and one weight bank per lane
	for (genvar b = 0; b < LANES; b++) begin : g_bank
		logic [PIX_W-1:0]        src_mem [SBANK_D];
		logic signed [WGT_W-1:0] wgt_mem [WBANK_D];

		always_ff @(posedge clk) begin
			if (pix_we && (item.position[LANE_W-1:0] == LANE_W'(b))) begin
				src_mem[item.position[LINE_AW-1:LANE_W]] <= item.pixel;
			end
			if (cmd.issue) begin
				src_rd_s1[b] <= src_mem[src_addr[b][LINE_AW-1:LANE_W]];
			end
		end

		always_ff @(posedge clk) begin
			if (wgt_we && (item.tap[LANE_W-1:0] == LANE_W'(b))) begin
				wgt_mem[{item.position, item.tap[TAP_W-1:LANE_W]}] <= item.weight;
			end
			if (cmd.issue) begin
				wgt_rd_s1[b] <= wgt_mem[wgt_raddr];
			end
		end
	end

	// Stage 1 side info
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			rot_s1     <= base[LANE_W-1:0];
			src_ok_s1  <= src_ok;
			lane_on_s1 <= lane_on;
		end
	end

	// Route banks to lanes; lanes outside the window and off-line taps carry zero
	always_comb begin
		logic [LANE_W-1:0] bsel;
		for (int j = 0; j < LANES; j++) begin
			bsel     = rot_s1 + LANE_W'(j);
			px_l[j]  = (lane_on_s1[j] && src_ok_s1[bsel]) ? src_rd_s1[bsel] : '0;
			wgt_l[j] = lane_on_s1[j] ? wgt_rd_s1[j] : '0;
		end
	end

	// Stage 2: lane products
	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			for (int j = 0; j < LANES; j++) begin
				prod_s2[j] <= $signed({1'b0, px_l[j]}) * wgt_l[j];
			end
		end
	end

	always_comb begin
		lane_sum = '0;
		for (int j = 0; j < LANES; j++) begin
			lane_sum = lane_sum + ACC_W'(prod_s2[j]);
		end
	end

	// Accumulator, preset with the rounding bias
	always_ff @(posedge clk) begin
		if (cmd.rd_start) begin
			acc_q <= ACC_BIAS;
		end else if (cmd.acc) begin
			acc_q <= acc_q + lane_sum;
		end
	end

	// Output register: floor shift by FRAC_BITS, clip to 0..255
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (acc_q[ACC_W-1]) begin
				out_pixel_q <= '0;
				out_sat_q   <= 1'b1;
			end else if (|acc_q[ACC_W-2:FRAC_BITS+PIX_W]) begin
				out_pixel_q <= PIX_MAX;
				out_sat_q   <= 1'b1;
			end else begin
				out_pixel_q <= acc_q[FRAC_BITS+PIX_W-1:FRAC_BITS];
				out_sat_q   <= 1'b0;
			end
		end
	end

	assign out_pixel = out_pixel_q;
	assign out_sat   = out_sat_q;

endmodule

### hw/rtl/lrm_ctrl.sv
// Controller of the line resampler: command decode, tap-group sequencing,
// pipeline tracking and the output handshake. Uses lrm_pkg.
`timescale 1ns / 1ps

module lrm_ctrl import lrm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      s_tvalid,
	input  cmd_code_t command,
	input  logic      m_tready,
	input  dp_stat_t  stat,
	output logic      s_tready,
	output logic      m_tvalid,
	output dp_cmd_t   cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_WIN    = 5'b00010,
		ST_RUN    = 5'b00100,
		ST_DRAIN  = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t            state_q, state_d;
	logic [GCNT_W-1:0] grp_q;
	logic [GCNT_W-1:0] groups;
	logic [LEN_W:0]    len_rnd;
	logic              mul_pend_q, acc_pend_q;
	logic              out_valid_q;
	logic              accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	// Number of four-tap groups in the window
	assign len_rnd = {1'b0, stat.len} + (LEN_W+1)'(LANES - 1);
	assign groups  = GCNT_W'(len_rnd >> LANE_W);

	// Commands
	always_comb begin
		cmd           = '0;
		cmd.accept    = accept;
		cmd.rd_start  = accept && (command == CMD_READ);
		cmd.win_latch = (state_q == ST_WIN);
		cmd.issue     = (state_q == ST_RUN) && (grp_q < groups);
		cmd.grp       = grp_q[GRP_W-1:0];
		cmd.mul       = mul_pend_q;
		cmd.acc       = acc_pend_q;
		cmd.out_load  = (state_q == ST_FINISH) && (!out_valid_q || m_tready);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (cmd.rd_start) state_d = ST_WIN;
			ST_WIN:    state_d = ST_RUN;
			ST_RUN:    if (!cmd.issue) state_d = ST_DRAIN;
			ST_DRAIN:  if (!mul_pend_q && !acc_pend_q) state_d = ST_FINISH;
			ST_FINISH: if (cmd.out_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			grp_q       <= '0;
			mul_pend_q  <= 1'b0;
			acc_pend_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			mul_pend_q <= cmd.issue;
			acc_pend_q <= mul_pend_q;
			// group counter
			if (state_q == ST_WIN) begin
				grp_q <= '0;
			end else if (cmd.issue) begin
				grp_q <= grp_q + GCNT_W'(1);
			end
			// output slot
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = out_valid_q;

`ifndef SYNTH
	// A result never overwrites one that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || m_tready))
		else $error("output register overwritten");

	// Group issue stays inside the window
	a_issue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (grp_q < groups) && (grp_q < GCNT_W'(TAPS_MAX / LANES)))
		else $error("tap group issued beyond window");

	// Window latch only in the cycle after a read transfer
	a_win_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.win_latch |-> $past(cmd.rd_start))
		else $error("window latched without read");

	// No result while products are still in flight
	a_drain_done: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !mul_pend_q && !acc_pend_q)
		else $error("result loaded before accumulation finished");
`endif

endmodule

### hw/rtl/line_resample_mac_top.sv
// Top level of the line resampler MAC: stream ports, configuration port,
// controller and datapath. Uses lrm_pkg, lrm_ctrl, lrm_datapath.
`timescale 1ns / 1ps

// Resamples one 8-bit grey line with per-output windows and signed Q22 weights.
// Write commands (weight, window, source pixel) give no result. A read command
// reads its window entry, latches the window length L (clamped to taps_in_use and
// 32), issues the ceil(L/4) tap groups to the multiply lanes, drains the products
// into the accumulator and loads the rounded, clipped pixel into the output
// register. The four multiply lanes, each fed by its own pixel bank and weight
// bank, cover four taps per cycle. One command is worked on at a time;
// a finished result sits in an output register, so further commands are taken
// while it waits. The memories are not cleared at reset: entries read by a window
// must be written first.

module line_resample_mac_top import lrm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// command stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // position[9:0], tap[14:10], weight[38:15],
	                              // window_start[48:39], window_length[54:49], pixel[62:55]
	input  logic [1:0]  s_tuser,  // command[1:0]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // out_pixel[7:0]
	output logic        m_tuser,  // saturated[0]
	// configuration: taps_in_use
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [5:0]  cfg_data
);

	in_item_t item;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Unpack the command transfer
	assign item.command       = cmd_code_t'(s_tuser);
	assign item.position      = s_tdata[9:0];
	assign item.tap           = s_tdata[14:10];
	assign item.weight        = s_tdata[38:15];
	assign item.window_start  = s_tdata[48:39];
	assign item.window_length = s_tdata[54:49];
	assign item.pixel         = s_tdata[62:55];

	assign cfg_ready = 1'b1;

	lrm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.command  (item.command),
		.m_tready (m_tready),
		.stat     (stat),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.cmd      (cmd)
	);

	lrm_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_taps  (cfg_data),
		.item      (item),
		.cmd       (cmd),
		.stat      (stat),
		.out_pixel (m_tdata),
		.out_sat   (m_tuser)
	);

endmodule

### sim/line_resample_mac_top_tb.sv
// Self-checking testbench for line_resample_mac_top: directed and random command traffic,
// results compared against an in-bench model of the weighted window sum.
// Depends on lrm_pkg and the line_resample_mac_top RTL.
`timescale 1ns / 1ps

module line_resample_mac_top_tb;
	import lrm_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_PAUSE = 20;
	localparam int RANDOM_ITEMS = 1850;
	localparam int HOT_POS = 16;

	typedef struct packed {
		logic [PIX_W-1:0] out_pixel;
		logic             saturated;
	} px_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [63:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [5:0]  cfg_data = '0;

	// Model state and write tracking
	logic [PIX_W-1:0]        line_px   [LINE_MAX];
	logic signed [WGT_W-1:0] wgt_mem   [OUT_MAX*TAPS_MAX];
	logic [POS_W-1:0]        win_start [OUT_MAX];
	logic [LEN_W-1:0]        win_len   [OUT_MAX];
	bit                      src_ok    [LINE_MAX];
	bit                      wgt_ok    [OUT_MAX*TAPS_MAX];
	bit                      win_ok    [OUT_MAX];
	logic [LEN_W-1:0]        taps_cur = TAPS_RESET;

	px_result_t pending_px[$];
	int mismatches = 0;
	int sent_items = 0;
	int cycle_cnt = 0;
	int send_gap_pct = 0;
	int stall_pct = 0;

	line_resample_mac_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Window length actually summed for an output position
	function automatic int span_len(int p);
		int n;
		n = win_len[p];
		if (n > taps_cur) n = taps_cur;
		if (n > TAPS_MAX) n = TAPS_MAX;
		return n;
	endfunction

	// Updates the model on an accepted command; a read queues its expected pixel
	function automatic void apply_command(in_item_t it);
		longint acc;
		longint q;
		int base;
		int src;
		px_result_t r;
		base = int'(it.position) * TAPS_MAX;
		case (it.command)
			CMD_WR_WEIGHT: begin
				wgt_mem[base + int'(it.tap)] = it.weight;
				wgt_ok[base + int'(it.tap)] = 1'b1;
			end
			CMD_WR_WINDOW: begin
				win_start[it.position] = it.window_start;
				win_len[it.position] = it.window_length;
				win_ok[it.position] = 1'b1;
			end
			CMD_WR_PIXEL: begin
				line_px[it.position] = it.pixel;
				src_ok[it.position] = 1'b1;
			end
			CMD_READ: begin
				acc = longint'(1) <<< (FRAC_BITS - 1);
				for (int i = 0; i < span_len(it.position); i++) begin
					src = int'(win_start[it.position]) + i;
					// pixels past the end of the line contribute nothing
					if (src < LINE_MAX)
						acc += longint'(line_px[src]) * longint'(wgt_mem[base + i]);
				end
				q = acc >>> FRAC_BITS;
				if (q < 0) begin
					r.out_pixel = '0;
					r.saturated = 1'b1;
				end else if (q > 255) begin
					r.out_pixel = PIX_MAX;
					r.saturated = 1'b1;
				end else begin
					r.out_pixel = PIX_W'(q);
					r.saturated = 1'b0;
				end
				pending_px.push_back(r);
			end
		endcase
	endfunction

	// Random filler for the fields a command does not use
	function automatic in_item_t junk_item();
		logic [95:0] raw;
		raw = {$urandom, $urandom, $urandom};
		return raw[$bits(in_item_t)-1:0];
	endfunction

	function automatic logic signed [WGT_W-1:0] rand_weight();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 20) return WGT_W'($urandom);
		if (pick < 25) return {1'b1, {(WGT_W-1){1'b0}}};
		if (pick < 30) return {1'b0, {(WGT_W-1){1'b1}}};
		// weights from -0.125 to 0.25 so most sums stay in 0..255
		return WGT_W'(int'($urandom_range(0, 1572864)) - 524288);
	endfunction

	function automatic logic [PIX_W-1:0] rand_pixel();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) return '0;
		if (pick == 1) return PIX_MAX;
		return PIX_W'($urandom_range(0, 255));
	endfunction

	// One command transfer, with a random gap before it
	task automatic send_item(in_item_t it);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, it.pixel, it.window_length, it.window_start, it.weight,
		             it.tap, it.position};
		s_tuser  <= it.command;
		do @(posedge clk); while (!s_tready);
		apply_command(it);
		sent_items++;
	endtask

	task automatic wr_weight(int p, int t, logic signed [WGT_W-1:0] w);
		in_item_t it;
		it = junk_item();
		it.command = CMD_WR_WEIGHT;
		it.position = POS_W'(p);
		it.tap = TAP_W'(t);
		it.weight = w;
		send_item(it);
	endtask

	task automatic wr_window(int p, int start, int len);
		in_item_t it;
		it = junk_item();
		it.command = CMD_WR_WINDOW;
		it.position = POS_W'(p);
		it.window_start = POS_W'(start);
		it.window_length = LEN_W'(len);
		send_item(it);
	endtask

	task automatic wr_pixel(int p, logic [PIX_W-1:0] v);
		in_item_t it;
		it = junk_item();
		it.command = CMD_WR_PIXEL;
		it.position = POS_W'(p);
		it.pixel = v;
		send_item(it);
	endtask

	task automatic rd_out(int p);
		in_item_t it;
		it = junk_item();
		it.command = CMD_READ;
		it.position = POS_W'(p);
		send_item(it);
	endtask

	// Random window: mostly short and near the line start, some running off the end
	task automatic rand_window(int p);
		int pick;
		int start;
		int len;
		pick = $urandom_range(0, 99);
		if (pick < 80) start = $urandom_range(0, 127);
		else if (pick < 90) start = $urandom_range(992, LINE_MAX - 1);
		else start = $urandom_range(0, LINE_MAX - 1);
		pick = $urandom_range(0, 99);
		if (pick < 5) len = 0;
		else if (pick < 65) len = $urandom_range(1, 8);
		else if (pick < 85) len = $urandom_range(9, 32);
		else len = $urandom_range(33, 63);
		wr_window(p, start, len);
	endtask

	// Writes whatever the read would touch but has never been written, then reads
	task automatic fill_and_read(int p);
		int src;
		if (!win_ok[p]) rand_window(p);
		for (int i = 0; i < span_len(p); i++) begin
			if (!wgt_ok[p*TAPS_MAX + i]) wr_weight(p, i, rand_weight());
			src = int'(win_start[p]) + i;
			if (src < LINE_MAX && !src_ok[src]) wr_pixel(src, rand_pixel());
		end
		rd_out(p);
	endtask

	// Register write, only once the block has gone quiet
	task automatic set_taps(logic [LEN_W-1:0] v);
		s_tvalid <= 1'b0;
		while (pending_px.size() != 0) @(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		taps_cur = v;
	endtask

	// Single-tap windows: unity gain and round-half-up
	task automatic test_identity();
		wr_pixel(5, 8'd201);
		wr_weight(1, 0, WGT_W'(1 << (FRAC_BITS - 1)));
		wr_window(1, 5, 1);
		rd_out(1);
		wr_weight(1, 0, WGT_W'(1 << FRAC_BITS));
		rd_out(1);
	endtask

	// Most negative and most positive weight clip low and high
	task automatic test_saturation();
		wr_pixel(6, PIX_MAX);
		wr_window(2, 6, 1);
		wr_weight(2, 0, {1'b1, {(WGT_W-1){1'b0}}});
		rd_out(2);
		wr_weight(2, 0, {1'b0, {(WGT_W-1){1'b1}}});
		rd_out(2);
	endtask

	// Zero-length window, zero taps in use, long window cut by the tap count
	task automatic test_empty_window();
		wr_window(3, 0, 0);
		rd_out(3);
		set_taps(6'd0);
		rd_out(1);
		set_taps(6'd1);
		wr_window(1, 5, 63);
		rd_out(1);
		set_taps(TAPS_RESET);
	endtask

	// Last output position, window running past the last source pixel
	task automatic test_line_end();
		wr_pixel(LINE_MAX - 2, 8'd0);
		wr_pixel(LINE_MAX - 1, PIX_MAX);
		wr_window(OUT_MAX - 1, LINE_MAX - 2, 3);
		wr_weight(OUT_MAX - 1, TAPS_MAX - 1, {1'b0, {(WGT_W-1){1'b1}}});
		fill_and_read(OUT_MAX - 1);
	endtask

	task automatic random_action();
		int pick;
		int hot;
		pick = $urandom_range(0, 99);
		hot = $urandom_range(0, HOT_POS - 1);
		if (pick < 40) begin
			if ($urandom_range(0, 3) == 0) rand_window(hot);
			fill_and_read(hot);
		end else if (pick < 47) begin
			hot = $urandom_range(0, OUT_MAX - 1);
			rand_window(hot);
			fill_and_read(hot);
		end else if (pick < 62) begin
			if ($urandom_range(0, 1)) hot = $urandom_range(0, OUT_MAX - 1);
			wr_weight(hot, $urandom_range(0, TAPS_MAX - 1), rand_weight());
		end else if (pick < 77) begin
			if ($urandom_range(0, 4) == 0) wr_pixel($urandom_range(0, LINE_MAX - 1), rand_pixel());
			else wr_pixel($urandom_range(0, 160), rand_pixel());
		end else if (pick < 87) begin
			rand_window(hot);
		end else begin
			// burst of reads over prepared positions
			repeat (3) fill_and_read($urandom_range(0, HOT_POS - 1));
		end
	endtask

	// Random traffic over several tap settings and backpressure patterns
	task automatic test_random_traffic();
		int taps_set [4] = '{9, 63, 1, 32};
		int gap_set  [4] = '{0, 76, 0, 20};
		int stall_set[4] = '{0, 0, 76, 20};
		int first;
		for (int ph = 0; ph < 4; ph++) begin
			set_taps(LEN_W'(taps_set[ph]));
			send_gap_pct = gap_set[ph];
			stall_pct = stall_set[ph];
			first = sent_items;
			while (sent_items - first < RANDOM_ITEMS / 4) random_action();
		end
		send_gap_pct = 0;
		stall_pct = 0;
	endtask

	// Result checker and receiver backpressure
	always @(posedge clk) begin : result_check
		px_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_px.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result: out_pixel %0d saturated %0b",
					         $time, m_tdata, m_tuser);
			end else begin
				want = pending_px.pop_front();
				if (m_tdata !== want.out_pixel || m_tuser !== want.saturated) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: mismatch: expected out_pixel %0d saturated %0b, got %0d %0b",
						         $time, want.out_pixel, want.saturated, m_tdata, m_tuser);
				end
			end
		end
		m_tready <= ($urandom_range(0, 99) >= stall_pct);
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_identity();
		test_saturation();
		test_empty_window();
		test_line_end();
		test_random_traffic();
		s_tvalid <= 1'b0;
		while (pending_px.size() != 0) @(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
